// ----- hdl/rpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared constants, codes and control types of the page allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int NUM_PAGES   = 32768;
  localparam int PAGE_SHIFT  = 12;
  localparam int COUNT_WIDTH = 8;

  localparam int ADDR_W     = 27;
  localparam int TOP_ADDR_W = 28;
  localparam int CFG_W      = 28;
  localparam int REQ_W      = 3;
  localparam int OUT_CNT_W  = 8;
  localparam int STATUS_W   = 3;

  localparam int PNUM_W    = $clog2(NUM_PAGES);
  localparam int FTOP_W    = $clog2(NUM_PAGES) + 1;
  localparam int PN_FULL_W = ADDR_W - PAGE_SHIFT;

  localparam logic [TOP_ADDR_W-1:0] TOP_ADDR_RST = TOP_ADDR_W'(134217728);

  typedef enum logic [REQ_W-1:0] {
    REQ_SEED  = 3'd0,
    REQ_ALLOC = 3'd1,
    REQ_FREE  = 3'd2,
    REQ_INC   = 3'd3,
    REQ_DEC   = 3'd4,
    REQ_GET   = 3'd5
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_EMPTY = 3'd1,
    STAT_BAD   = 3'd2,
    STAT_ZERO  = 3'd3,
    STAT_SAT   = 3'd4,
    STAT_FULL  = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    REG_LOWEST_PAGE_ADDR = 1'b0,
    REG_TOP_ADDR         = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic commit;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- hdl/rpa_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_req_if / rpa_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface rpa_req_if;
  import rpa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [ADDR_W-1:0]        page_addr;

  modport source (output valid, output req_type, output page_addr, input ready);
  modport sink   (input valid, input req_type, input page_addr, output ready);
endinterface

interface rpa_rsp_if;
  import rpa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ADDR_W-1:0]        alloc_addr;
  logic [OUT_CNT_W-1:0]     ref_count;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output alloc_addr, output ref_count, output status,
                  input ready);
  modport sink   (input valid, input alloc_addr, input ref_count, input status,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/rpa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/rpa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_ctrl
// Sequencer: clearing pass after reset, request capture, update.
// ----------------------------------------------------------------------------
module rpa_ctrl
  import rpa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output      logic      req_ready_o,
  input  wire dp_stat_t  stat_i,
  output      ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!stat_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o   = (state_q == S_IDLE);
  assign cmd_o.capture = (state_q == S_IDLE) && req_valid_i;
  assign cmd_o.commit  = (state_q == S_EXEC) && !stat_i.out_busy;
  assign cmd_o.clear   = (state_q == S_CLEAR);

endmodule
`default_nettype wire

// ----- hdl/rpa_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_dp
// Datapath: address check, count and free-page memories, pool pointer,
// configuration registers and response register.
// ----------------------------------------------------------------------------
module rpa_dp
  import rpa_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ctrl_cmd_t              cmd_i,
  output      dp_stat_t               stat_o,
  input  wire logic [REQ_W-1:0]       req_type_i,
  input  wire logic [ADDR_W-1:0]      page_addr_i,
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_data_i,
  input  wire logic                   rsp_ready_i,
  output      logic                   rsp_valid_o,
  output      logic [ADDR_W-1:0]      alloc_addr_o,
  output      logic [OUT_CNT_W-1:0]   ref_count_o,
  output      logic [STATUS_W-1:0]    status_o
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [ADDR_W-1:0]      lowest_q;
  logic [TOP_ADDR_W-1:0]  top_addr_q;
  logic [FTOP_W-1:0]      free_top_q, free_top_d;
  logic [PNUM_W-1:0]      clr_q;

  logic [REQ_W-1:0]       req_q;
  logic [PNUM_W-1:0]      pnum_q;
  logic                   ok_q;

  logic                   out_valid_q;
  logic [ADDR_W-1:0]      alloc_addr_q, alloc_addr_d;
  logic [OUT_CNT_W-1:0]   ref_count_q, ref_count_d;
  logic [STATUS_W-1:0]    status_q, status_d;

  logic [PN_FULL_W-1:0]   pn_full;
  logic [TOP_ADDR_W-1:0]  page_end;
  logic                   addr_ok;

  logic [COUNT_WIDTH-1:0] cnt_rdata;
  logic [PNUM_W-1:0]      stk_rdata;

  logic                   upd_we;
  logic [PNUM_W-1:0]      upd_waddr;
  logic [COUNT_WIDTH-1:0] upd_wdata;
  logic                   cnt_we;
  logic [PNUM_W-1:0]      cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic                   push;
  logic                   pop;
  logic                   pool_full;
  logic                   pool_empty;

  assign pn_full  = page_addr_i[ADDR_W-1:PAGE_SHIFT];
  assign page_end = TOP_ADDR_W'(page_addr_i) + TOP_ADDR_W'(1 << PAGE_SHIFT);
  assign addr_ok  = (page_addr_i[PAGE_SHIFT-1:0] == '0)
                 && (page_addr_i >= lowest_q)
                 && (page_end <= top_addr_q)
                 && (32'(pn_full) < 32'(NUM_PAGES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q   <= '0;
      top_addr_q <= TOP_ADDR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOWEST_PAGE_ADDR: lowest_q   <= cfg_data_i[ADDR_W-1:0];
        REG_TOP_ADDR:         top_addr_q <= cfg_data_i[TOP_ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      pnum_q <= PNUM_W'(pn_full);
      ok_q   <= addr_ok;
    end
  end

  rpa_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_PAGES)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (PNUM_W'(pn_full)),
    .rdata_o (cnt_rdata)
  );

  rpa_ram #(.WIDTH(PNUM_W), .DEPTH(NUM_PAGES)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (free_top_q[PNUM_W-1:0]),
    .wdata_i (pnum_q),
    .re_i    (cmd_i.capture),
    .raddr_i (PNUM_W'(free_top_q - FTOP_W'(1))),
    .rdata_o (stk_rdata)
  );

  assign pool_full  = (free_top_q == FTOP_W'(NUM_PAGES));
  assign pool_empty = (free_top_q == '0);

  always_comb begin
    alloc_addr_d = '0;
    ref_count_d  = '0;
    status_d     = STAT_OK;
    upd_we       = 1'b0;
    upd_waddr    = pnum_q;
    upd_wdata    = '0;
    push         = 1'b0;
    pop          = 1'b0;
    if (req_q == REQ_ALLOC) begin
      if (pool_empty) begin
        status_d = STAT_EMPTY;
      end else begin
        pop          = 1'b1;
        upd_we       = 1'b1;
        upd_waddr    = stk_rdata;
        upd_wdata    = COUNT_WIDTH'(1);
        alloc_addr_d = ADDR_W'({stk_rdata, {PAGE_SHIFT{1'b0}}});
        ref_count_d  = OUT_CNT_W'(1);
      end
    end else if (req_q == REQ_SEED || req_q == REQ_FREE || req_q == REQ_INC
                 || req_q == REQ_DEC || req_q == REQ_GET) begin
      if (!ok_q) begin
        status_d = STAT_BAD;
      end else begin
        ref_count_d = OUT_CNT_W'(cnt_rdata);
        case (req_q)
          REQ_SEED: begin
            if (pool_full) begin
              status_d = STAT_FULL;
            end else begin
              upd_we      = 1'b1;
              push        = 1'b1;
              ref_count_d = '0;
            end
          end
          REQ_FREE: begin
            if (cnt_rdata == '0) begin
              status_d = STAT_ZERO;
            end else if (cnt_rdata == COUNT_WIDTH'(1) && pool_full) begin
              status_d = STAT_FULL;
            end else begin
              upd_we      = 1'b1;
              upd_wdata   = cnt_rdata - COUNT_WIDTH'(1);
              push        = (cnt_rdata == COUNT_WIDTH'(1));
              ref_count_d = OUT_CNT_W'(upd_wdata);
            end
          end
          REQ_INC: begin
            if (cnt_rdata == '0) begin
              status_d = STAT_ZERO;
            end else if (cnt_rdata == COUNT_MAX) begin
              status_d = STAT_SAT;
            end else begin
              upd_we      = 1'b1;
              upd_wdata   = cnt_rdata + COUNT_WIDTH'(1);
              ref_count_d = OUT_CNT_W'(upd_wdata);
            end
          end
          REQ_DEC: begin
            if (cnt_rdata == '0) begin
              status_d = STAT_ZERO;
            end else begin
              upd_we      = 1'b1;
              upd_wdata   = cnt_rdata - COUNT_WIDTH'(1);
              ref_count_d = OUT_CNT_W'(upd_wdata);
            end
          end
          default: ;
        endcase
      end
    end
    if (!cmd_i.commit) begin
      upd_we = 1'b0;
      push   = 1'b0;
      pop    = 1'b0;
    end
  end

  assign cnt_we    = cmd_i.clear || upd_we;
  assign cnt_waddr = cmd_i.clear ? clr_q : upd_waddr;
  assign cnt_wdata = cmd_i.clear ? '0 : upd_wdata;

  always_comb begin
    free_top_d = free_top_q;
    if (push) begin
      free_top_d = free_top_q + FTOP_W'(1);
    end else if (pop) begin
      free_top_d = free_top_q - FTOP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_top_q  <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      free_top_q <= free_top_d;
      if (cmd_i.clear) begin
        clr_q <= clr_q + PNUM_W'(1);
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      alloc_addr_q <= alloc_addr_d;
      ref_count_q  <= ref_count_d;
      status_q     <= status_d;
    end
  end

  assign stat_o.clear_last = (clr_q == PNUM_W'(NUM_PAGES - 1));
  assign stat_o.out_busy   = out_valid_q && !rsp_ready_i;

  assign rsp_valid_o  = out_valid_q;
  assign alloc_addr_o = alloc_addr_q;
  assign ref_count_o  = ref_count_q;
  assign status_o     = status_q;

endmodule
`default_nettype wire

// ----- hdl/refcounted_page_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// Physical page allocator with per-page reference counts and a LIFO pool
// of free pages.
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   req_type, page_addr
//   rsp_o    out  valid/ready   alloc_addr, ref_count, status
//   cfg      in   cfg_we_i      cfg_idx_i, cfg_data_i (write only)
//
// Each request is handled as a capture with memory reads, then an update of
// the count memory, the free-page stack and the response register.
// One request is in flight at a time; the read-modify-write of the count
// memory, with no forwarding between requests, sets this rate.
// After reset a clearing pass zeroes all NUM_PAGES entries of the count memory
// with req_i.ready low. Configuration writes are taken throughout.
// A response not yet taken holds the next request in its update cycle.
// ----------------------------------------------------------------------------
module refcounted_page_allocator
  import rpa_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  rpa_req_if.sink               req_i,
  rpa_rsp_if.source             rsp_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      req_ready;

  rpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rpa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_type_i   (req_i.req_type),
    .page_addr_i  (req_i.page_addr),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .alloc_addr_o (rsp_o.alloc_addr),
    .ref_count_o  (rsp_o.ref_count),
    .status_o     (rsp_o.status)
  );

  assign req_i.ready = req_ready;

endmodule
`default_nettype wire

// ----- hdl/rpa_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_checker
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module rpa_checker
  import rpa_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 req_valid_i,
  input wire logic                 req_ready_i,
  input wire logic                 rsp_valid_i,
  input wire logic                 rsp_ready_i,
  input wire logic [ADDR_W-1:0]    rsp_alloc_addr_i,
  input wire logic [OUT_CNT_W-1:0] rsp_ref_count_i,
  input wire logic [STATUS_W-1:0]  rsp_status_i
);

  logic req_fire;

  assign req_fire = req_valid_i && req_ready_i;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before taken");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_fire)
    else $error("request taken while previous one in update");

  a_rsp_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_fire, 2))
    else $error("response without request two cycles earlier");

  a_fault_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != STAT_OK |-> rsp_alloc_addr_i == '0)
    else $error("faulted request returned an address");

  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_alloc_addr_i != '0 |->
      rsp_ref_count_i == OUT_CNT_W'(1) && rsp_status_i == STAT_OK)
    else $error("allocated page without count of one");

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_alloc_addr_i (rsp_o.alloc_addr),
  .rsp_ref_count_i  (rsp_o.ref_count),
  .rsp_status_i     (rsp_o.status)
);
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the refcounted page allocator. Requests are driven
// from a backlog queue, each accepted request is run through a local model of
// the page counts and the free-page pool, and every response is compared
// field by field with the oldest predicted one. Phases move the page window
// through its extremes and pump one count into saturation.
// ----------------------------------------------------------------------------
module tb;
  import rpa_pkg::*;

  localparam int PAGE_BYTES  = 1 << PAGE_SHIFT;
  localparam int COUNT_MAX   = (1 << COUNT_WIDTH) - 1;
  localparam int STALL_LIMIT = 4 * NUM_PAGES + 2000;
  localparam int SETTLE      = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int ERR_PRINTS  = 100;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_HI = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [ADDR_W-1:0] addr;
  } page_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    alloc_addr;
    logic [OUT_CNT_W-1:0] count;
    status_e              status;
  } page_rsp_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  cfg_reg_e              cfg_idx;
  logic [CFG_W-1:0]      cfg_data;

  rpa_req_if req_if ();
  rpa_rsp_if rsp_if ();

  refcounted_page_allocator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // model of the allocator
  logic [COUNT_WIDTH-1:0] page_refs  [NUM_PAGES];
  logic [PNUM_W-1:0]      pool_stack [NUM_PAGES];
  int                     pool_depth;
  logic [ADDR_W-1:0]      win_lo;
  logic [TOP_ADDR_W-1:0]  win_top;

  page_req_t req_backlog[$];
  page_rsp_t awaited_rsps[$];
  page_req_t cur_req;

  int first_pn, last_pn;
  int hot_pn [8];
  int n_errors, n_sent, n_rsps;
  int send_wait, recv_wait;
  int calm_left [2];
  logic hold_rsp;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic page_rsp_t serve_request(input page_req_t rq);
    page_rsp_t r;
    longint unsigned a;
    logic [PNUM_W-1:0] pn;
    logic [COUNT_WIDTH-1:0] c;
    r.alloc_addr = '0;
    r.count      = '0;
    r.status     = STAT_OK;
    a = longint'(rq.addr);
    if (rq.kind == REQ_ALLOC) begin
      if (pool_depth == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        pool_depth--;
        pn = pool_stack[pool_depth];
        page_refs[pn] = COUNT_WIDTH'(1);
        r.alloc_addr = ADDR_W'(longint'(pn) << PAGE_SHIFT);
        r.count = OUT_CNT_W'(1);
      end
    end else if (rq.kind <= REQ_GET) begin
      if (rq.addr[PAGE_SHIFT-1:0] != '0 || rq.addr < win_lo ||
          a + PAGE_BYTES > longint'(win_top) || (a >> PAGE_SHIFT) >= NUM_PAGES) begin
        r.status = STAT_BAD;
      end else begin
        pn = PNUM_W'(a >> PAGE_SHIFT);
        c = page_refs[pn];
        r.count = OUT_CNT_W'(c);
        case (rq.kind)
          REQ_SEED: begin
            if (pool_depth >= NUM_PAGES) begin
              r.status = STAT_FULL;
            end else begin
              page_refs[pn] = '0;
              pool_stack[pool_depth] = pn;
              pool_depth++;
              r.count = '0;
            end
          end
          REQ_FREE: begin
            if (c == 0) begin
              r.status = STAT_ZERO;
            end else if (c == 1 && pool_depth >= NUM_PAGES) begin
              r.status = STAT_FULL;
            end else begin
              page_refs[pn] = c - 1'b1;
              if (c == 1) begin
                pool_stack[pool_depth] = pn;
                pool_depth++;
              end
              r.count = OUT_CNT_W'(c - 1'b1);
            end
          end
          REQ_INC: begin
            if (c == 0) r.status = STAT_ZERO;
            else if (c == COUNT_MAX) r.status = STAT_SAT;
            else begin
              page_refs[pn] = c + 1'b1;
              r.count = OUT_CNT_W'(c + 1'b1);
            end
          end
          REQ_DEC: begin
            if (c == 0) r.status = STAT_ZERO;
            else begin
              page_refs[pn] = c - 1'b1;
              r.count = OUT_CNT_W'(c - 1'b1);
            end
          end
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  function automatic int idle_cycles(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm_left[side] = $urandom_range(10, 40);
    return $urandom_range(0, 12);
  endfunction

  task automatic report(input string msg);
    if (n_errors < ERR_PRINTS) $display("ERROR at %0t: %s", $time, msg);
    n_errors++;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.req_type  <= '0;
      req_if.page_addr <= '0;
      send_wait = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        awaited_rsps.push_back(serve_request(cur_req));
        n_sent++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          req_if.valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          cur_req = req_backlog.pop_front();
          req_if.valid     <= 1'b1;
          req_if.req_type  <= cur_req.kind;
          req_if.page_addr <= cur_req.addr;
          send_wait = idle_cycles(0);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk_i or negedge rst_ni) begin
    page_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        n_rsps++;
        if (awaited_rsps.size() == 0) begin
          report($sformatf("response %0d with no request outstanding", n_rsps));
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp_if.alloc_addr !== want.alloc_addr)
            report($sformatf("response %0d: alloc_addr %h, want %h",
                             n_rsps, rsp_if.alloc_addr, want.alloc_addr));
          if (rsp_if.ref_count !== want.count)
            report($sformatf("response %0d: ref_count %0d, want %0d",
                             n_rsps, rsp_if.ref_count, want.count));
          if (rsp_if.status !== want.status)
            report($sformatf("response %0d: status %0d, want %0d",
                             n_rsps, rsp_if.status, want.status));
        end
        recv_wait = idle_cycles(1);
      end
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // stall watchdog
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // hold off responses so the allocator backs up into its request port
  initial begin
    hold_rsp = 1'b0;
    wait (n_sent >= 40);
    @(posedge clk_i);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rsp <= 1'b0;
  end

  function automatic logic [ADDR_W-1:0] page_at(input int pn);
    return ADDR_W'(pn << PAGE_SHIFT);
  endfunction

  function automatic void queue_req(input logic [REQ_W-1:0] kind,
                                    input logic [ADDR_W-1:0] addr);
    page_req_t rq;
    rq.kind = kind;
    rq.addr = addr;
    req_backlog.push_back(rq);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    case ($urandom_range(0, 19))
      0:       return ADDR_W'($urandom);
      1:       return page_at(hot_pn[$urandom_range(0, 7)]) | ADDR_W'($urandom_range(1, 4095));
      2:       return page_at(first_pn);
      3:       return page_at(first_pn - 1);
      4:       return page_at(last_pn);
      5:       return page_at(last_pn + 1);
      default: return page_at(hot_pn[$urandom_range(0, 7)]);
    endcase
  endfunction

  function automatic void add_random(input int n);
    int goal;
    int k;
    logic [ADDR_W-1:0] a;
    goal = req_backlog.size() + n;
    while (req_backlog.size() < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          a = page_at(hot_pn[$urandom_range(0, 7)]);
          queue_req(REQ_SEED, a);
          queue_req(REQ_ALLOC, ADDR_W'($urandom));
          k = $urandom_range(0, 4);
          repeat (k) queue_req(REQ_INC, a);
          queue_req(REQ_GET, a);
          repeat ($urandom_range(0, k + 2))
            queue_req(($urandom_range(0, 3) == 0) ? REQ_DEC : REQ_FREE, a);
        end
        6, 7, 8: queue_req(REQ_W'($urandom_range(REQ_SEED, REQ_GET)), pick_addr());
        default: queue_req(REQ_W'($urandom_range(REQ_SEED, REQ_UNKNOWN_HI)), ADDR_W'($urandom));
      endcase
    end
  endfunction

  task automatic set_window(input logic [ADDR_W-1:0] lo, input logic [TOP_ADDR_W-1:0] top);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_LOWEST_PAGE_ADDR;
    cfg_data <= CFG_W'(lo);
    @(posedge clk_i);
    cfg_idx  <= REG_TOP_ADDR;
    cfg_data <= CFG_W'(top);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    win_lo  = lo;
    win_top = top;
    first_pn = int'((longint'(lo) + PAGE_BYTES - 1) >> PAGE_SHIFT);
    last_pn  = int'(longint'(top) >> PAGE_SHIFT) - 1;
    hot_pn[0] = first_pn;
    hot_pn[1] = last_pn;
    for (int i = 2; i < 8; i++)
      hot_pn[i] = (last_pn >= first_pn) ? $urandom_range(first_pn, last_pn)
                                        : $urandom_range(0, NUM_PAGES - 1);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (req_backlog.size() != 0 || req_if.valid || awaited_rsps.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  initial begin
    int sat_pn;
    logic [ADDR_W-1:0] a;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = '0;
    req_if.page_addr = '0;
    rsp_if.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_LOWEST_PAGE_ADDR;
    cfg_data         = '0;
    n_errors = 0;
    n_sent   = 0;
    n_rsps   = 0;
    calm_left[0] = 0;
    calm_left[1] = 0;
    foreach (page_refs[i]) page_refs[i] = '0;
    pool_depth = 0;
    win_lo  = '0;
    win_top = TOP_ADDR_RST;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // full address range, directed
    set_window('0, TOP_ADDR_RST);
    queue_req(REQ_ALLOC, 27'h7FFFFFF);
    queue_req(REQ_GET,   27'h0000000);
    queue_req(REQ_INC,   27'h0000000);
    queue_req(REQ_DEC,   27'h0000000);
    queue_req(REQ_FREE,  27'h0000000);
    queue_req(REQ_SEED,  27'h0000000);
    queue_req(REQ_SEED,  27'h7FFF000);
    queue_req(REQ_ALLOC, 27'h0000000);
    queue_req(REQ_INC,   27'h7FFF000);
    queue_req(REQ_SEED,  27'h7FFF000);
    queue_req(REQ_ALLOC, 27'h5555555);
    queue_req(REQ_DEC,   27'h7FFF000);
    queue_req(REQ_GET,   27'h7FFF000);
    queue_req(REQ_ALLOC, 27'h2AAAAAA);
    queue_req(REQ_ALLOC, 27'h0000000);
    queue_req(REQ_FREE,  27'h0000000);
    queue_req(REQ_SEED,  27'h7FFFFFF);
    queue_req(REQ_GET,   27'h0000800);
    queue_req(REQ_FREE,  27'h4000000);
    queue_req(REQ_UNKNOWN_LO, 27'h7FFFFFF);
    queue_req(REQ_UNKNOWN_HI, 27'h5555000);
    queue_req(REQ_ALLOC, 27'h0000000);
    queue_req(REQ_INC,   27'h0000000);
    queue_req(REQ_GET,   27'h0000000);
    wait_idle();

    set_window(27'h0100000, 28'h2000000);
    add_random(60);
    wait_idle();

    // no page fits above the lowest address
    set_window(27'h7FFFFFF, 28'h8000000);
    add_random(20);
    wait_idle();

    set_window(27'h0123456, 28'h4000800);
    add_random(60);
    wait_idle();

    set_window('0, '0);
    add_random(20);
    wait_idle();

    // pump one count into saturation
    set_window('0, 28'h8000000);
    sat_pn = hot_pn[2];
    a = page_at(sat_pn);
    queue_req(REQ_SEED, a);
    queue_req(REQ_ALLOC, '0);
    repeat (COUNT_MAX + 1) queue_req(REQ_INC, a);
    queue_req(REQ_GET, a);
    queue_req(REQ_DEC, a);
    queue_req(REQ_DEC, a);
    queue_req(REQ_INC, a);
    add_random(60);
    wait_idle();

    add_random(40);
    wait_idle();

    if (n_errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- refcounted_page_allocator.f -----
hdl/rpa_pkg.sv
hdl/rpa_if.sv
hdl/rpa_ram.sv
hdl/rpa_ctrl.sv
hdl/rpa_dp.sv
hdl/refcounted_page_allocator.sv
hdl/rpa_checker.sv
bench/tb.sv
